### sv/minv_pkg.sv
package minv_pkg;

    localparam int WORD_W = 32;
    localparam int THR_W  = 31;
    localparam int N_ELEM = 9;

    typedef logic signed [WORD_W-1:0] word_t;

    typedef struct packed {
        word_t m11;
        word_t m12;
        word_t m13;
        word_t m21;
        word_t m22;
        word_t m23;
        word_t m31;
        word_t m32;
        word_t m33;
    } mat_in_t;

    typedef struct packed {
        word_t r11;
        word_t r12;
        word_t r13;
        word_t r21;
        word_t r22;
        word_t r23;
        word_t r31;
        word_t r32;
        word_t r33;
        logic  singular;
        logic  overflowed;
    } mat_out_t;

    // Adjugate entry k = m[a]*m[b] - m[c]*m[d], entries numbered row by row;
    // the table already holds the transposed cofactors.
    localparam int COF_IDX [N_ELEM][4] = '{
        '{4, 8, 5, 7},
        '{2, 7, 1, 8},
        '{1, 5, 2, 4},
        '{5, 6, 3, 8},
        '{0, 8, 2, 6},
        '{2, 3, 0, 5},
        '{3, 7, 4, 6},
        '{1, 6, 0, 7},
        '{0, 4, 1, 3}
    };

endpackage

### sv/minv_cof.sv
// One cofactor lane: register both products, then their difference.
module minv_cof (
    input  logic                                 clk,
    input  logic                                 en1,
    input  logic                                 en2,
    input  minv_pkg::word_t                      x,
    input  minv_pkg::word_t                      y,
    input  minv_pkg::word_t                      u,
    input  minv_pkg::word_t                      v,
    output logic signed [2*minv_pkg::WORD_W:0]   adj
);
    localparam int PW = 2 * minv_pkg::WORD_W;
    localparam int AW = PW + 1;

    logic signed [PW-1:0] pxy_reg;
    logic signed [PW-1:0] puv_reg;
    logic signed [AW-1:0] adj_reg;
    logic signed [AW-1:0] adj_next;

    assign adj_next = AW'(pxy_reg) - AW'(puv_reg);

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            pxy_reg <= PW'(x) * PW'(y);
            puv_reg <= PW'(u) * PW'(v);
        end
        if (en2)
        begin
            adj_reg <= adj_next;
        end
    end

    assign adj = adj_reg;
endmodule

### sv/minv_div.sv
// One divider lane: overflow pre-check, then one restoring quotient bit per stage.
module minv_div #(
    parameter int FRAC_BITS = 24
) (
    input  logic                                     clk,
    input  logic [minv_pkg::WORD_W:0]                en,
    input  logic [2*minv_pkg::WORD_W+2*FRAC_BITS-1:0] num,
    input  logic [3*minv_pkg::WORD_W:0]              den,
    input  logic                                     neg,
    output logic [minv_pkg::WORD_W-1:0]              q,
    output logic                                     big,
    output logic                                     neg_q
);
    localparam int W  = minv_pkg::WORD_W;
    localparam int NW = 2 * W + 2 * FRAC_BITS;
    localparam int DW = 3 * W + 1;
    localparam int CW = ((NW > DW) ? NW : DW) + 1;

    logic [NW-1:0] r_reg   [0:W-1];
    logic [DW-1:0] d_reg   [0:W-1];
    logic [W-1:0]  q_reg   [0:W];
    logic          big_reg [0:W];
    logic          neg_reg [0:W];
    logic          big_next;

    // Quotient reaches 2^W exactly when num >= den << W.
    assign big_next = CW'(num >> W) >= CW'(den);

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            r_reg[0]   <= num;
            d_reg[0]   <= den;
            q_reg[0]   <= '0;
            big_reg[0] <= big_next;
            neg_reg[0] <= neg;
        end
    end

    for (genvar j = 1; j <= W; j++)
    begin : g_step
        localparam int B = W - j;
        logic          ge;
        logic [W-1:0]  q_next;

        always_comb
        begin
            ge        = CW'(r_reg[j-1] >> B) >= CW'(d_reg[j-1]);
            q_next    = q_reg[j-1];
            q_next[B] = ge;
        end

        always_ff @(posedge clk)
        begin
            if (en[j])
            begin
                q_reg[j]   <= q_next;
                big_reg[j] <= big_reg[j-1];
                neg_reg[j] <= neg_reg[j-1];
            end
        end

        if (j < W)
        begin : g_rem
            always_ff @(posedge clk)
            begin
                if (en[j])
                begin
                    r_reg[j] <= ge ? r_reg[j-1] - (NW'(d_reg[j-1]) << B) : r_reg[j-1];
                    d_reg[j] <= d_reg[j-1];
                end
            end
        end
    end

    assign q     = q_reg[W];
    assign big   = big_reg[W];
    assign neg_q = neg_reg[W];
endmodule

### sv/matrix3x3_inverse.sv
// 3x3 matrix inverse, signed fixed point (32-bit words, FRAC_BITS fraction bits).
// Input channel in_valid/in_ready/in_data carries one matrix per transaction;
// output channel out_valid/out_ready/out_data returns its inverse, row by row,
// with a singular flag (all entries zero) and an overflowed flag (some entry
// saturated). Configuration channel cfg_valid/cfg_ready/cfg_data writes the
// singular threshold in units of one LSB; it is always ready. Write it only
// while the block is empty.
// A matrix passes the cofactor product and difference stages, the determinant
// partial-product and sum stages, the magnitude and threshold check, then
// WORD_W + 1 divider stages (an overflow pre-check, then one quotient bit per
// stage in each of nine parallel lanes) and the output register. Throughput:
// one matrix per cycle while out_ready stays high. Every stage advances on its
// own when the stage behind it is empty, so a stalled receiver only holds the
// output register and the queue fills toward it; in_ready falls once all stages
// hold a transaction. Reset empties the pipeline and sets the threshold to 1.
module matrix3x3_inverse #(
    parameter int FRAC_BITS = 24
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  minv_pkg::mat_in_t     in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output minv_pkg::mat_out_t    out_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [minv_pkg::THR_W-1:0] cfg_data
);
    localparam int W    = minv_pkg::WORD_W;
    localparam int NE   = minv_pkg::N_ELEM;
    localparam int AW   = 2 * W + 1;
    localparam int PW   = 2 * W + 1;
    localparam int DETW = 3 * W + 2;
    localparam int DW   = 3 * W + 1;
    localparam int TW   = minv_pkg::THR_W + 2 * FRAC_BITS;
    localparam int KW   = ((DW > TW) ? DW : TW) + 1;
    localparam int DS   = 6;
    localparam int NS   = W + 7;

    // ---------------- stage control ----------------
    logic [NS+1:1] en;
    logic [NS:1]   v_reg;
    logic [NS:1]   v_next;

    // Advance a stage when it is empty or the one behind it advances.
    always_comb
    begin
        en[NS+1] = out_ready;
        for (int k = NS; k >= 1; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    assign v_next = {v_reg[NS-1:1], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            for (int k = 1; k <= NS; k++)
            begin
                if (en[k])
                begin
                    v_reg[k] <= v_next[k];
                end
            end
        end
    end

    assign in_ready  = en[1];
    assign out_valid = v_reg[NS];

    // ---------------- threshold register ----------------
    logic [minv_pkg::THR_W-1:0] thr_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= minv_pkg::THR_W'(1);
        end
        else if (cfg_valid)
        begin
            thr_reg <= cfg_data;
        end
    end

    // ---------------- stages 1-2: cofactor lanes ----------------
    minv_pkg::word_t m [NE];

    assign m[0] = in_data.m11;
    assign m[1] = in_data.m12;
    assign m[2] = in_data.m13;
    assign m[3] = in_data.m21;
    assign m[4] = in_data.m22;
    assign m[5] = in_data.m23;
    assign m[6] = in_data.m31;
    assign m[7] = in_data.m32;
    assign m[8] = in_data.m33;

    logic signed [AW-1:0] adj [NE];

    for (genvar k = 0; k < NE; k++)
    begin : g_cof
        minv_cof u_cof (
            .clk (clk),
            .en1 (en[1]),
            .en2 (en[2]),
            .x   (m[minv_pkg::COF_IDX[k][0]]),
            .y   (m[minv_pkg::COF_IDX[k][1]]),
            .u   (m[minv_pkg::COF_IDX[k][2]]),
            .v   (m[minv_pkg::COF_IDX[k][3]]),
            .adj (adj[k])
        );
    end

    // Hold the first row alongside the cofactors for the determinant.
    minv_pkg::word_t row1_reg [3];
    minv_pkg::word_t row2_reg [3];

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < 3; j++)
        begin
            if (en[1])
            begin
                row1_reg[j] <= m[j];
            end
            if (en[2])
            begin
                row2_reg[j] <= row1_reg[j];
            end
        end
    end

    // ---------------- stage 3: determinant partial products ----------------
    // det = m11*adj0 + m12*adj3 + m13*adj6; each of these is split into a low
    // unsigned word and a high signed part so no factor exceeds a word and a sign.
    logic signed [PW-1:0]  plo_reg [3];
    logic signed [PW-1:0]  phi_reg [3];
    logic signed [AW-1:0]  a3_reg  [NE];

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            for (int j = 0; j < 3; j++)
            begin
                plo_reg[j] <= PW'(row2_reg[j]) * PW'($signed({1'b0, adj[3*j][W-1:0]}));
                phi_reg[j] <= PW'(row2_reg[j]) * PW'($signed(adj[3*j][AW-1:W]));
            end
            for (int k = 0; k < NE; k++)
            begin
                a3_reg[k] <= adj[k];
            end
        end
    end

    // ---------------- stage 4: determinant sum ----------------
    logic signed [DETW-1:0] det_reg;
    logic signed [DETW-1:0] det_next;
    logic signed [AW-1:0]   a4_reg [NE];

    always_comb
    begin
        det_next = '0;
        for (int j = 0; j < 3; j++)
        begin
            det_next = det_next + (DETW'(phi_reg[j]) <<< W) + DETW'(plo_reg[j]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            det_reg <= det_next;
            for (int k = 0; k < NE; k++)
            begin
                a4_reg[k] <= a3_reg[k];
            end
        end
    end

    // ---------------- stage 5: magnitudes, signs, singular check ----------------
    logic                 det_neg;
    logic [DETW-1:0]      det_mag;
    logic [DW-1:0]        dabs_next;
    logic                 sing_next;
    logic [DW-1:0]        dabs_reg;
    logic                 sing5_reg;
    logic [2*W-1:0]       aabs_reg [NE];
    logic                 neg5_reg [NE];

    always_comb
    begin
        det_neg   = det_reg[DETW-1];
        det_mag   = det_neg ? DETW'(-det_reg) : DETW'(det_reg);
        dabs_next = det_mag[DW-1:0];
        // Zero determinant counts as singular even with a zero threshold.
        sing_next = (det_reg == '0)
                 || (KW'(dabs_next) < (KW'(thr_reg) << (2 * FRAC_BITS)));
    end

    // An adjugate magnitude never exceeds 2^(2*W-1), so 2*W bits hold it.
    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            dabs_reg  <= dabs_next;
            sing5_reg <= sing_next;
            for (int k = 0; k < NE; k++)
            begin
                aabs_reg[k] <= (2*W)'(a4_reg[k][AW-1] ? -a4_reg[k] : a4_reg[k]);
                neg5_reg[k] <= a4_reg[k][AW-1] ^ det_neg;
            end
        end
    end

    // ---------------- stages 6..W+6: divider lanes ----------------
    logic [W-1:0] q     [NE];
    logic         big   [NE];
    logic         neg_q [NE];

    for (genvar k = 0; k < NE; k++)
    begin : g_div
        minv_div #(
            .FRAC_BITS (FRAC_BITS)
        ) u_div (
            .clk   (clk),
            .en    (en[DS+W:DS]),
            .num   ({aabs_reg[k], {(2*FRAC_BITS){1'b0}}}),
            .den   (dabs_reg),
            .neg   (neg5_reg[k]),
            .q     (q[k]),
            .big   (big[k]),
            .neg_q (neg_q[k])
        );
    end

    // Carry the singular flag alongside the divider stages.
    logic sg_reg [0:W];

    always_ff @(posedge clk)
    begin
        if (en[DS])
        begin
            sg_reg[0] <= sing5_reg;
        end
        for (int j = 1; j <= W; j++)
        begin
            if (en[DS+j])
            begin
                sg_reg[j] <= sg_reg[j-1];
            end
        end
    end

    // ---------------- output stage: saturate and merge lanes ----------------
    localparam logic [W-1:0] NEG_MAG = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0] POS_MAX = {1'b0, {(W-1){1'b1}}};

    logic [W-1:0]       res [NE];
    logic               sat [NE];
    logic               ovf_next;
    minv_pkg::mat_out_t out_next;
    minv_pkg::mat_out_t out_reg;

    always_comb
    begin
        ovf_next = 1'b0;
        for (int k = 0; k < NE; k++)
        begin
            if (neg_q[k])
            begin
                sat[k] = big[k] || (q[k] > NEG_MAG);
                res[k] = sat[k] ? NEG_MAG : W'(-q[k]);
            end
            else
            begin
                sat[k] = big[k] || q[k][W-1];
                res[k] = sat[k] ? POS_MAX : q[k];
            end
            // Drop everything for a singular matrix.
            if (sg_reg[W])
            begin
                res[k] = '0;
                sat[k] = 1'b0;
            end
            ovf_next = ovf_next || sat[k];
        end
        out_next.r11        = res[0];
        out_next.r12        = res[1];
        out_next.r13        = res[2];
        out_next.r21        = res[3];
        out_next.r22        = res[4];
        out_next.r23        = res[5];
        out_next.r31        = res[6];
        out_next.r32        = res[7];
        out_next.r33        = res[8];
        out_next.singular   = sg_reg[W];
        out_next.overflowed = ovf_next;
    end

    always_ff @(posedge clk)
    begin
        if (en[NS])
        begin
            out_reg <= out_next;
        end
    end

    assign out_data = out_reg;
endmodule

### test/minv_checker.sv
module minv_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  minv_pkg::mat_in_t             in_data,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  minv_pkg::mat_out_t            out_data,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [minv_pkg::THR_W-1:0]    cfg_data,
    output int                            n_errors,
    output int                            n_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC = 24;

    typedef logic signed [127:0] wide_t;

    minv_pkg::mat_out_t         inverse_q[$];
    logic [minv_pkg::THR_W-1:0] det_floor;

    function automatic minv_pkg::mat_out_t invert_matrix(minv_pkg::mat_in_t mi,
                                                         logic [minv_pkg::THR_W-1:0] floor_v);
        wide_t              e [9];
        wide_t              adj [9];
        wide_t              det;
        wide_t              dabs;
        wide_t              thr;
        wide_t              num;
        wide_t              q;
        minv_pkg::word_t    r [9];
        logic               ovf;
        minv_pkg::mat_out_t res;
        e[0] = mi.m11; e[1] = mi.m12; e[2] = mi.m13;
        e[3] = mi.m21; e[4] = mi.m22; e[5] = mi.m23;
        e[6] = mi.m31; e[7] = mi.m32; e[8] = mi.m33;
        adj[0] = e[4]*e[8] - e[5]*e[7];
        adj[1] = e[2]*e[7] - e[1]*e[8];
        adj[2] = e[1]*e[5] - e[2]*e[4];
        adj[3] = e[5]*e[6] - e[3]*e[8];
        adj[4] = e[0]*e[8] - e[2]*e[6];
        adj[5] = e[2]*e[3] - e[0]*e[5];
        adj[6] = e[3]*e[7] - e[4]*e[6];
        adj[7] = e[1]*e[6] - e[0]*e[7];
        adj[8] = e[0]*e[4] - e[1]*e[3];
        det  = e[0]*adj[0] + e[1]*adj[3] + e[2]*adj[6];
        dabs = det < 0 ? -det : det;
        thr  = wide_t'(floor_v) <<< (2*FRAC);
        res  = '0;
        if (det == 0 || dabs < thr)
        begin
            res.singular = 1'b1;
            return res;
        end
        ovf = 1'b0;
        for (int k = 0; k < 9; k++)
        begin
            // |adj| < 2^63, shifted by 48 still fits 128 bits signed
            num = (adj[k] < 0 ? -adj[k] : adj[k]) <<< (2*FRAC);
            q   = num / dabs;
            if ((adj[k] < 0) != (det < 0))
            begin
                if (q > 128'sh8000_0000) begin q = 128'sh8000_0000; ovf = 1'b1; end
                r[k] = minv_pkg::word_t'(-q);
            end
            else
            begin
                if (q > 128'sh7FFF_FFFF) begin q = 128'sh7FFF_FFFF; ovf = 1'b1; end
                r[k] = minv_pkg::word_t'(q);
            end
        end
        res = {r[0], r[1], r[2], r[3], r[4], r[5], r[6], r[7], r[8], 1'b0, ovf};
        return res;
    endfunction

    assign n_pending = inverse_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            det_floor <= 1;
            n_errors  <= 0;
            inverse_q.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                det_floor <= cfg_data;
            if (in_valid && in_ready)
                inverse_q.push_back(invert_matrix(in_data, det_floor));
            if (out_valid && out_ready)
            begin
                if (inverse_q.size() == 0)
                begin
                    $display("%0t: unexpected result %h", $time, out_data);
                    n_errors <= n_errors + 1;
                end
                else
                begin
                    minv_pkg::mat_out_t want;
                    want = inverse_q.pop_front();
                    if (want !== out_data)
                    begin
                        $display("%0t: mismatch expected %h actual %h", $time, want, out_data);
                        $display("    r11 %h/%h r33 %h/%h sing %b/%b ovf %b/%b",
                                 want.r11, out_data.r11, want.r33, out_data.r33,
                                 want.singular, out_data.singular,
                                 want.overflowed, out_data.overflowed);
                        n_errors <= n_errors + 1;
                    end
                end
            end
        end
    end
endmodule

### test/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY  = 39;
    localparam int STALL_LIMIT = 5000;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       in_valid = 1'b0;
    logic                       in_ready;
    minv_pkg::mat_in_t          in_data = '0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    minv_pkg::mat_out_t         out_data;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [minv_pkg::THR_W-1:0] cfg_data = '0;
    int                         n_errors;
    int                         n_pending;

    // late part of the run: no idling on either side
    bit               quiet = 1'b0;
    // long receiver hold-offs requested and done, so the pipeline backs up into in_ready
    int               hold_req = 0;
    int               hold_done = 0;
    int               n_sent = 0;
    int               idle_cnt = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    matrix3x3_inverse i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    minv_checker i_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .n_errors  (n_errors),
        .n_pending (n_pending)
    );

    // Receiver: random stall bursts, or a long hold-off when asked.
    initial
    begin
        int burst;
        @(posedge rst_n);
        forever
        begin
            if (hold_done != hold_req)
            begin
                out_ready <= 1'b0;
                repeat (300) @(posedge clk);
                hold_done++;
            end
            else if (!quiet && $urandom_range(0, 3) == 0)
            begin
                burst = $urandom_range(1, 7);
                out_ready <= 1'b0;
                repeat (burst) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
        end
    end

    // Watchdog: count cycles with no transaction on either channel.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cnt <= 0;
        else
            idle_cnt <= idle_cnt + 1;
        if (idle_cnt >= STALL_LIMIT)
        begin
            $display("watchdog expired, %0d results outstanding", n_pending);
            $display("testbench: errors");
            $finish;
        end
    end

    function automatic minv_pkg::word_t rand_word(int kind);
        case (kind)
            0: return $urandom;
            1: return minv_pkg::word_t'($signed($urandom_range(0, 32'h0400_0000))
                                        - 32'sh0200_0000);
            2: return minv_pkg::word_t'($signed($urandom_range(0, 32'h0000_4000))
                                        - 32'sh0000_2000);
            default:
            begin
                case ($urandom_range(0, 5))
                    0: return 32'sh8000_0000;
                    1: return 32'sh7FFF_FFFF;
                    2: return 32'sh0100_0000;
                    3: return -32'sh0100_0000;
                    4: return 0;
                    default: return $urandom_range(0, 3) - 1;
                endcase
            end
        endcase
    endfunction

    // Offer one matrix, with an optional idle burst ahead of it.
    task automatic send_matrix(minv_pkg::mat_in_t mat);
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= mat;
        do @(posedge clk); while (!in_ready);
        n_sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (n_pending != 0) @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
    endtask

    task automatic write_floor(logic [minv_pkg::THR_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    function automatic minv_pkg::mat_in_t scaled_identity(minv_pkg::word_t a);
        minv_pkg::mat_in_t mat;
        mat = '0;
        mat.m11 = a; mat.m22 = a; mat.m33 = a;
        return mat;
    endfunction

    task automatic random_phase(int count, int mode);
        minv_pkg::mat_in_t mat;
        minv_pkg::word_t   w [9];
        int                kind;
        for (int n = 0; n < count; n++)
        begin
            kind = (mode >= 0) ? mode : $urandom_range(0, 3);
            foreach (w[k]) w[k] = rand_word(kind);
            // sometimes copy the first row into the third to reach the singular path
            if ($urandom_range(0, 9) == 0)
                w[6:8] = w[0:2];
            mat = {w[0], w[1], w[2], w[3], w[4], w[5], w[6], w[7], w[8]};
            send_matrix(mat);
        end
    endtask

    initial
    begin
        minv_pkg::mat_in_t mat;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: identity, scaled identities, extremes, singular cases
        send_matrix(scaled_identity(32'sh0100_0000));
        send_matrix(scaled_identity(-32'sh0100_0000));
        send_matrix(scaled_identity(32'sh0000_0001));
        send_matrix(scaled_identity(32'sh7FFF_FFFF));
        send_matrix(scaled_identity(32'sh8000_0000));
        send_matrix(scaled_identity(32'sh0080_0000));
        send_matrix('0);
        send_matrix('1);
        mat = {9{32'sh7FFF_FFFF}};
        send_matrix(mat);
        mat = {9{32'sh8000_0000}};
        send_matrix(mat);
        mat = {32'sh0100_0000, 32'sh0200_0000, 32'sh0300_0000,
               32'sh0000_0000, 32'sh0100_0000, 32'sh0400_0000,
               32'sh0500_0000, 32'sh0600_0000, 32'sh0000_0000};
        send_matrix(mat);
        mat = {32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0000_0001,
               32'sh7FFF_FFFF, 32'sh8000_0000, 32'shFFFF_FFFF,
               32'sh0000_0001, 32'shFFFF_FFFF, 32'sh8000_0000};
        send_matrix(mat);
        // tiny determinant just around the default floor
        send_matrix(scaled_identity(32'sh0001_0000));
        send_matrix(scaled_identity(32'sh0000_0100));
        drain();

        // zero floor: only exact zero determinants are singular
        write_floor('0);
        send_matrix('0);
        send_matrix(scaled_identity(32'sh0000_0001));
        random_phase(150, -1);
        drain();

        // largest floor: only matrices with full-scale entries escape the singular path
        write_floor('1);
        send_matrix(scaled_identity(32'sh7FFF_FFFF));
        send_matrix(scaled_identity(32'sh8000_0000));
        random_phase(100, -1);
        drain();

        // floor 2^-16, far below unit scale; hold off the receiver to fill the queue
        write_floor(31'h0000_0100);
        hold_req++;
        random_phase(300, 1);
        drain();

        write_floor(31'h5555_5555);
        random_phase(100, 0);
        drain();

        write_floor(1);
        random_phase(900, -1);
        quiet = 1'b1;
        random_phase(250, -1);
        drain();

        $display("covered %0d matrices over six threshold settings,", n_sent);
        $display("with idle bursts, a long output stall and singular/saturating cases");
        if (n_errors == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end
endmodule
